// ===== design/qins_pkg.sv =====
// Shared types, widths and codes for the positional-insert queue.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
`default_nettype none

package qins_pkg;

   // Storage size and derived widths
   localparam int DEPTH  = 64;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int DATA_W = 32;
   localparam int POS_W  = 7;
   localparam int OCC_W  = 7;
   localparam int KIND_W = 2;
   localparam int STAT_W = 2;
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((DATA_W + OCC_W + 7) / 8) * 8;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd2;

   // Result status codes
   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

   // Value returned by a pop that finds the queue empty (-64964)
   localparam logic [DATA_W-1:0] EMPTY_MARK = 32'hFFFF_023C;

   // Datapath operations
   localparam logic [1:0] OP_NONE   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;

   // Controller to datapath command
   typedef struct packed {
      logic              load;
      logic [1:0]        op;
      logic [IDX_W-1:0]  idx;
      logic [STAT_W-1:0] status;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             empty;
      logic             full;
   } stat_type;

endpackage

`default_nettype wire

// ===== design/qins_ctrl.sv =====
// Controller for the positional-insert queue: request decode, result-slot
// state machine and stream handshakes. Depends on qins_pkg.
`default_nettype none

module qins_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [qins_pkg::KIND_W-1:0]   req_kind,
   input  wire logic [qins_pkg::POS_W-1:0]    req_position,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire qins_pkg::stat_type            dp_stat,
   output qins_pkg::cmd_type                  dp_cmd
);
   import qins_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_HOLD = 1'b1;

   logic             state_ff;
   logic             state_in;
   logic             accept;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;

   // Take a new request whenever the result slot is free or being drained
   assign req_tready = (state_ff == S_IDLE) || rsp_tready;
   assign rsp_tvalid = (state_ff == S_HOLD);
   assign accept     = req_tvalid && req_tready;

   assign pos_ext = CMP_W'(req_position);
   assign cnt_ext = CMP_W'(dp_stat.count);

   // Decode the request into a datapath command
   always_comb begin
      dp_cmd        = '0;
      dp_cmd.load   = accept;
      dp_cmd.op     = OP_NONE;
      dp_cmd.idx    = IDX_W'(dp_stat.count);
      dp_cmd.status = STAT_OK;
      unique case (req_kind)
         KIND_PUSH: begin
            if (dp_stat.full) begin
               dp_cmd.status = STAT_FULL;
            end else begin
               dp_cmd.op = OP_INSERT;
            end
         end
         KIND_POP: begin
            if (dp_stat.empty) begin
               dp_cmd.status = STAT_EMPTY;
            end else begin
               dp_cmd.op = OP_POP;
            end
         end
         KIND_INSERT: begin
            if (req_position == '0) begin
               dp_cmd.status = STAT_BADPOS;
            end else if (dp_stat.full) begin
               dp_cmd.status = STAT_FULL;
            end else begin
               dp_cmd.op = OP_INSERT;
               // beyond the tail the value is appended
               if (pos_ext <= cnt_ext) begin
                  dp_cmd.idx = IDX_W'(pos_ext - 1'b1);
               end
            end
         end
         default: begin
            dp_cmd.op = OP_NONE;
         end
      endcase
   end

   // Result slot: fill on transfer in, empty on transfer out
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = S_HOLD;
      end else if (rsp_tready) begin
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/qins_dp.sv =====
// Datapath for the positional-insert queue: shifting entry registers,
// entry count and the result register. Depends on qins_pkg.
`default_nettype none

module qins_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire qins_pkg::cmd_type             dp_cmd,
   input  wire logic [qins_pkg::DATA_W-1:0]   req_value,
   output qins_pkg::stat_type                 dp_stat,
   output logic [qins_pkg::DATA_W-1:0]        rsp_head_value,
   output logic [qins_pkg::STAT_W-1:0]        rsp_status,
   output logic [qins_pkg::OCC_W-1:0]         rsp_occupancy
);
   import qins_pkg::*;

   logic [DATA_W-1:0] entries_ff [DEPTH];
   logic [DATA_W-1:0] entries_in [DEPTH];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [DATA_W-1:0] head_ff;
   logic [DATA_W-1:0] head_in;
   logic [STAT_W-1:0] status_ff;
   logic [OCC_W-1:0]  occ_ff;

   // Next value of every entry: hold, take a neighbour or take the new value
   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      always_comb begin
         entries_in[i] = entries_ff[i];
         if (dp_cmd.load && dp_cmd.op == OP_INSERT) begin
            if (IDX_W'(i) == dp_cmd.idx) begin
               entries_in[i] = req_value;
            end else if (IDX_W'(i) > dp_cmd.idx) begin
               entries_in[i] = entries_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (dp_cmd.load && dp_cmd.op == OP_POP) begin
            entries_in[i] = entries_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end

      always_ff @(posedge clock) begin
         entries_ff[i] <= entries_in[i];
      end
   end

   // Advance the count
   always_comb begin
      count_in = count_ff;
      if (dp_cmd.load && dp_cmd.op == OP_INSERT) begin
         count_in = count_ff + 1'b1;
      end else if (dp_cmd.load && dp_cmd.op == OP_POP) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Head value of the result
   always_comb begin
      head_in = '0;
      if (dp_cmd.op == OP_POP) begin
         head_in = entries_ff[0];
      end else if (dp_cmd.status == STAT_EMPTY) begin
         head_in = EMPTY_MARK;
      end
   end

   // Result register, loaded on each accepted request
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         head_ff   <= head_in;
         status_ff <= dp_cmd.status;
         occ_ff    <= OCC_W'(count_in);
      end
   end

   assign dp_stat.count  = count_ff;
   assign dp_stat.empty  = (count_ff == '0);
   assign dp_stat.full   = (count_ff == CNT_W'(DEPTH));
   assign rsp_head_value = head_ff;
   assign rsp_status     = status_ff;
   assign rsp_occupancy  = occ_ff;

endmodule

`default_nettype wire

// ===== design/queue_with_insert_at_position.sv =====
// Ordered queue of signed 32-bit values with push, pop and positional insert.
// Top level: joins the controller and the datapath. Depends on qins_pkg.
//
// Usage:
//   Requests arrive on the req_ stream: req_tuser carries the kind (push at
//   tail, pop head, insert at 1-based position), req_tdata the value and the
//   position. Every request gives exactly one result on the rsp_ stream:
//   rsp_tuser carries the status (ok, empty on pop, invalid position, full),
//   rsp_tdata the popped value and the occupancy after the request.
//   A result is valid in the cycle after its request transfer. Throughput
//   is one request per cycle while the receiver takes each result; every
//   entry register shifts toward the head or tail in parallel, so the
//   entry shift network alone sets the timing.
//   A result waits in an output register until taken. While the receiver
//   stalls with a result waiting, req_tready is low; it is high again in the
//   cycle the result transfers, so a new request may enter in that cycle.
//   Reset clears the count and the result slot; entry contents are left
//   as they are and are never read before being written.
//   A pop on an empty queue returns -64964; a full queue rejects inserts.
`default_nettype none

module queue_with_insert_at_position (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [31:0] value, [38:32] position, [39] zero
   input  wire logic [qins_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] kind
   input  wire logic [qins_pkg::KIND_W-1:0]       req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [31:0] head_value, [38:32] occupancy, [39] zero
   output logic [qins_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // [1:0] status
   output logic [qins_pkg::STAT_W-1:0]            rsp_tuser
);
   import qins_pkg::*;

   cmd_type           dp_cmd;
   stat_type          dp_stat;
   logic [DATA_W-1:0] head_value;
   logic [OCC_W-1:0]  occupancy;

   qins_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_kind     (req_tuser),
      .req_position (req_tdata[DATA_W +: POS_W]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .dp_stat      (dp_stat),
      .dp_cmd       (dp_cmd)
   );

   qins_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .req_value      (req_tdata[DATA_W-1:0]),
      .dp_stat        (dp_stat),
      .rsp_head_value (head_value),
      .rsp_status     (rsp_tuser),
      .rsp_occupancy  (occupancy)
   );

   // Pack the result payload, padding with zeros
   assign rsp_tdata = RSP_DATA_W'({occupancy, head_value});

endmodule

`default_nettype wire

// ===== design/qins_checker.sv =====
// Port-level checker for the positional-insert queue, bound to the top level.
// Depends on qins_pkg and queue_with_insert_at_position.
`default_nettype none

module qins_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [qins_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic [qins_pkg::STAT_W-1:0]       rsp_tuser
);
   import qins_pkg::*;

   // A result stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before transfer");

   // Every accepted request yields a result in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      !reset && req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no result after request transfer");

   // No result appears without a request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_tvalid && rsp_tready && !(req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result without request");

   // Empty status carries the empty mark and zero occupancy
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_EMPTY |->
         rsp_tdata[DATA_W-1:0] == EMPTY_MARK && rsp_tdata[DATA_W +: OCC_W] == '0)
      else $error("empty result malformed");

   // Full status reports a full queue
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_FULL |->
         rsp_tdata[DATA_W +: OCC_W] == OCC_W'(DEPTH))
      else $error("full result with wrong occupancy");

endmodule

bind queue_with_insert_at_position qins_checker u_qins_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== bench/queue_with_insert_at_position_test.sv =====
`timescale 1ns / 100ps
// Stream-level test of the positional-insert queue: random and directed requests,
// each result checked against a shadow copy of the queue. Depends on qins_pkg.

module queue_with_insert_at_position_test;
   import qins_pkg::*;

   // Kind code that the block ignores
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 10;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [DATA_W-1:0] value;
      logic [POS_W-1:0]  position;
      int unsigned       send_idle;
      int unsigned       recv_stall;
      bit                hold_off;
   } request_item_type;

   typedef struct {
      logic [DATA_W-1:0] head_value;
      logic [STAT_W-1:0] status;
      logic [OCC_W-1:0]  occupancy;
   } queue_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;

   request_item_type  request_backlog[$];
   queue_outcome_type outcome_fifo[$];
   logic [DATA_W-1:0] shadow_entries[$];

   request_item_type issue_item;
   bit          req_took;
   int unsigned recv_stall_pct;
   int unsigned mismatch_count;
   int unsigned cycle_count;

   // Stimulus planning state
   int          plan_count;
   int unsigned phase_send_idle;
   int unsigned phase_recv_stall;
   bit          hold_next;

   queue_with_insert_at_position uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request to the shadow queue and return what the block should answer
   function automatic queue_outcome_type predict_outcome(logic [KIND_W-1:0] kind,
                                                         logic [DATA_W-1:0] value,
                                                         logic [POS_W-1:0] position);
      queue_outcome_type res;
      res.head_value = '0;
      res.status     = STAT_OK;
      case (kind)
         KIND_PUSH: begin
            if (shadow_entries.size() >= DEPTH) res.status = STAT_FULL;
            else shadow_entries.push_back(value);
         end
         KIND_POP: begin
            if (shadow_entries.size() == 0) begin
               res.head_value = EMPTY_MARK;
               res.status     = STAT_EMPTY;
            end else begin
               res.head_value = shadow_entries.pop_front();
            end
         end
         KIND_INSERT: begin
            // position zero is rejected before fullness is looked at
            if (position == 0) res.status = STAT_BADPOS;
            else if (shadow_entries.size() >= DEPTH) res.status = STAT_FULL;
            else if (position > shadow_entries.size()) shadow_entries.push_back(value);
            else shadow_entries.insert(position - 1, value);
         end
         default: ;
      endcase
      res.occupancy = OCC_W'(shadow_entries.size());
      return res;
   endfunction

   function automatic void note_mismatch(string field, logic [DATA_W-1:0] want,
                                         logic [DATA_W-1:0] got);
      if (mismatch_count < 10)
         $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
      mismatch_count++;
   endfunction

   // Drive requests and receiver readiness at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (request_backlog.size() != 0) recv_stall_pct = request_backlog[0].recv_stall;
         rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
         // hold the current request until it transfers
         if (!req_tvalid || req_took) begin
            if (request_backlog.size() != 0
                && !(request_backlog[0].hold_off && outcome_fifo.size() != 0)
                && $urandom_range(99, 0) >= request_backlog[0].send_idle) begin
               issue_item = request_backlog.pop_front();
               req_tuser  <= issue_item.kind;
               req_tdata  <= {{(REQ_DATA_W - DATA_W - POS_W){1'b0}},
                              issue_item.position, issue_item.value};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Sample transfers at the rising edge: check results, then predict new ones
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("queue_with_insert_at_position_test failed");
         $finish;
      end else begin
         req_took = 1'b0;
         if (!reset) begin
            if (rsp_tvalid && rsp_tready) begin
               if (outcome_fifo.size() == 0) begin
                  if (mismatch_count < 10)
                     $display("%0t: unexpected result %h status %h",
                              $time, rsp_tdata, rsp_tuser);
                  mismatch_count++;
               end else begin
                  queue_outcome_type want;
                  want = outcome_fifo.pop_front();
                  if (rsp_tdata[DATA_W-1:0] !== want.head_value)
                     note_mismatch("head_value", want.head_value, rsp_tdata[DATA_W-1:0]);
                  if (rsp_tuser !== want.status)
                     note_mismatch("status", DATA_W'(want.status), DATA_W'(rsp_tuser));
                  if (rsp_tdata[DATA_W +: OCC_W] !== want.occupancy)
                     note_mismatch("occupancy", DATA_W'(want.occupancy),
                                   DATA_W'(rsp_tdata[DATA_W +: OCC_W]));
               end
            end
            if (req_tvalid && req_tready) begin
               req_took = 1'b1;
               outcome_fifo.push_back(predict_outcome(req_tuser, req_tdata[DATA_W-1:0],
                                                      req_tdata[DATA_W +: POS_W]));
            end
         end
      end
   end

   // Append one request to the backlog and track the occupancy it should leave
   task automatic queue_request(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] value,
                                logic [POS_W-1:0] position);
      request_item_type item;
      item.kind       = kind;
      item.value      = value;
      item.position   = position;
      item.send_idle  = phase_send_idle;
      item.recv_stall = phase_recv_stall;
      item.hold_off   = hold_next;
      hold_next       = 1'b0;
      request_backlog.push_back(item);
      case (kind)
         KIND_PUSH:   if (plan_count < DEPTH) plan_count++;
         KIND_POP:    if (plan_count > 0) plan_count--;
         KIND_INSERT: if (position != 0 && plan_count < DEPTH) plan_count++;
         default: ;
      endcase
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 8) return 32'h7FFF_FFFF;
      if (roll < 16) return 32'h8000_0000;
      if (roll < 20) return 32'h0000_0000;
      if (roll < 24) return 32'hFFFF_FFFF;
      return $urandom();
   endfunction

   // Favour the head, the tail, just past the tail and far beyond it
   function automatic logic [POS_W-1:0] pick_position();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 5) return '0;
      if (roll < 20) return POS_W'(1);
      if (roll < 35) return POS_W'((plan_count == 0) ? 1 : plan_count);
      if (roll < 50) return POS_W'(plan_count + 1);
      if (roll < 60) return POS_W'(127);
      if (roll < 70) return POS_W'($urandom_range(127, plan_count + 1));
      return POS_W'($urandom_range(plan_count + 1, 1));
   endfunction

   // One random request: add_pct adds, pop_pct pops, the rest is noise
   task automatic queue_random(int unsigned add_pct, int unsigned pop_pct);
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < add_pct) begin
         if ($urandom_range(1, 0)) queue_request(KIND_PUSH, pick_value(), POS_W'($urandom()));
         else queue_request(KIND_INSERT, pick_value(), pick_position());
      end else if (roll < add_pct + pop_pct) begin
         queue_request(KIND_POP, $urandom(), POS_W'($urandom()));
      end else if ($urandom_range(1, 0)) begin
         queue_request(KIND_UNUSED, $urandom(), POS_W'($urandom()));
      end else begin
         queue_request(KIND_INSERT, pick_value(), '0);
      end
   endtask

   initial begin
      int unsigned send_plan[4];
      int unsigned stall_plan[4];
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = KIND_PUSH;
      rsp_tready     = 1'b0;
      req_took       = 1'b0;
      recv_stall_pct = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      plan_count     = 0;
      hold_next      = 1'b0;
      send_plan      = '{0, 85, 0, 14};
      stall_plan     = '{0, 0, 85, 14};

      // Directed: empty queue, field extremes, head/middle/tail inserts, ignored kind
      phase_send_idle  = 0;
      phase_recv_stall = 0;
      queue_request(KIND_POP, 32'h0, 7'd0);
      queue_request(KIND_INSERT, 32'h5555_5555, 7'd0);
      queue_request(KIND_UNUSED, 32'hFFFF_FFFF, 7'd127);
      queue_request(KIND_INSERT, 32'h8000_0000, 7'd127);
      queue_request(KIND_PUSH, 32'h7FFF_FFFF, 7'd0);
      queue_request(KIND_PUSH, 32'h0000_0000, 7'd127);
      queue_request(KIND_INSERT, 32'hFFFF_FFFF, 7'd1);
      queue_request(KIND_INSERT, 32'h1234_5678, 7'd3);
      queue_request(KIND_INSERT, 32'hCAFE_0001, 7'd6);
      queue_request(KIND_INSERT, 32'hCAFE_0002, 7'd6);
      queue_request(KIND_PUSH, 32'h8000_0000, 7'd0);
      queue_request(KIND_UNUSED, 32'hAAAA_AAAA, 7'd42);
      queue_request(KIND_INSERT, 32'h0F0F_0F0F, 7'd0);
      repeat (8) queue_request(KIND_POP, 32'h0, 7'd0);

      // Random phases: fill past full, drain past empty, then a balanced mix
      for (int p = 0; p < 4; p++) begin
         phase_send_idle  = send_plan[p];
         phase_recv_stall = stall_plan[p];
         hold_next        = 1'b1;
         while (plan_count < DEPTH) queue_random(80, 12);
         queue_request(KIND_INSERT, pick_value(), '0);
         queue_request(KIND_INSERT, pick_value(), pick_position());
         queue_request(KIND_PUSH, pick_value(), POS_W'($urandom()));
         repeat (8) queue_random(80, 5);
         while (plan_count > 0) queue_random(10, 85);
         repeat (4) queue_random(10, 85);
         repeat (180) queue_random(45, 45);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: all requests out, all results in, then let the pipe settle
      while (request_backlog.size() != 0 || req_tvalid) @(posedge clock);
      while (outcome_fifo.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("queue_with_insert_at_position_test passed");
      end else begin
         $display("queue_with_insert_at_position_test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/qins_pkg.sv
design/qins_ctrl.sv
design/qins_dp.sv
design/queue_with_insert_at_position.sv
design/qins_checker.sv
bench/queue_with_insert_at_position_test.sv
